>>> rtl/qme_pkg.sv
package qme_pkg;

  localparam int unsigned MAX_AXIS_STEPS_DEF = 32;
  localparam int unsigned LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef struct packed {
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic              left_button;
    logic              right_button;
  } qme_in_t;

  typedef struct packed {
    logic [1:0] x_drive;
    logic [1:0] y_drive;
    logic       left_drive;
    logic       right_drive;
    logic       last_step;
  } qme_out_t;

  typedef struct packed {
    logic load;
    logic emit;
  } qme_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
    logic done;
  } qme_sts_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_STEP = 2'b10
  } qme_state_t;

  // Gray walk: forward 0,1,3,2; backward the reverse.
  function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic fwd);
    logic [1:0] nxt;
    case (ph)
      2'd0: nxt = fwd ? 2'd1 : 2'd2;
      2'd1: nxt = fwd ? 2'd3 : 2'd0;
      2'd3: nxt = fwd ? 2'd2 : 2'd1;
      2'd2: nxt = fwd ? 2'd0 : 2'd3;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

endpackage

>>> rtl/quadrature_mouse_emulator.sv
// Channel  Direction  Handshake           Payload
// in       in         in_valid/in_stall   qme_in_t report (dx, dy, buttons)
// out      out        out_valid/out_stall qme_out_t pin-drive phase step
// cfg      in         cfg_valid/cfg_ready step_limit write data
//
// A report yields n results, where n = max(1, clamped |dx| + clamped |dy|),
// at most 64 with the default MAX_AXIS_STEPS. One phase step per cycle, while
// the output is not stalled, goes through the single shared step unit.
// Synchronous active-high reset: phases, buttons zero; step_limit 32.
// A stalled output holds the step unit; the next report is taken while the
// last result of the previous one still waits in the output register.
module quadrature_mouse_emulator #(
  parameter int unsigned MAX_AXIS_STEPS = qme_pkg::MAX_AXIS_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qme_pkg::qme_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qme_pkg::qme_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qme_pkg::LIMIT_W-1:0] cfg_data
);
  import qme_pkg::*;

  qme_cmd_t cmd;
  qme_sts_t sts;
  logic     busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  qme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  qme_datapath #(
    .MAX_AXIS_STEPS (MAX_AXIS_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("no work started after report transfer");

  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !sts.last) |=> in_stall)
    else $error("report released before its last step");

  a_idle_counts_clear: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> sts.done)
    else $error("step counts left over while idle");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("step emitted without output valid");

endmodule

>>> rtl/qme_ctrl.sv
module qme_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qme_pkg::qme_sts_t sts,
  output qme_pkg::qme_cmd_t cmd,
  output logic              busy
);
  import qme_pkg::*;

  qme_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/qme_datapath.sv
module qme_datapath #(
  parameter int unsigned MAX_AXIS_STEPS = qme_pkg::MAX_AXIS_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  qme_pkg::qme_in_t            in_data,
  input  logic                        cfg_write,
  input  logic [qme_pkg::LIMIT_W-1:0] cfg_data,
  input  qme_pkg::qme_cmd_t           cmd,
  output qme_pkg::qme_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qme_pkg::qme_out_t           out_data
);
  import qme_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_AXIS_STEPS + 1);
  localparam logic [7:0] MAX8 = 8'(MAX_AXIS_STEPS);

  logic [LIMIT_W-1:0] step_limit;
  logic [1:0]         x_phase, y_phase;
  logic [1:0]         button_drive;
  logic [CNT_W-1:0]   nx, ny;
  logic               xfwd, yfwd;

  logic [7:0] raw_x, raw_y, mag_x, mag_y, lim8, cnt_x, cnt_y;
  logic [1:0] x_step, y_step;
  logic       x_active;

  always_comb begin
    raw_x = in_data.dx;
    raw_y = in_data.dy;
    mag_x = raw_x[7] ? (~raw_x + 8'd1) : raw_x;
    mag_y = raw_y[7] ? (~raw_y + 8'd1) : raw_y;
    lim8  = {2'b00, step_limit};
    if (lim8 > MAX8) begin
      lim8 = MAX8;
    end
    cnt_x = (mag_x > lim8) ? lim8 : mag_x;
    cnt_y = (mag_y > lim8) ? lim8 : mag_y;
  end

  assign x_active = (nx != '0);
  assign x_step   = next_phase(x_phase, xfwd);
  assign y_step   = next_phase(y_phase, yfwd);

  assign sts.out_free = !out_valid || !out_stall;
  assign sts.done     = (nx == '0) && (ny == '0);
  assign sts.last     = ((nx == '0) && (ny <= CNT_W'(1))) ||
                        ((nx == CNT_W'(1)) && (ny == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit   <= LIMIT_RESET;
      x_phase      <= 2'd0;
      y_phase      <= 2'd0;
      button_drive <= 2'd0;
      nx           <= '0;
      ny           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        step_limit <= cfg_data;
      end
      if (cmd.load) begin
        button_drive <= {in_data.right_button, in_data.left_button};
        nx           <= cnt_x[CNT_W-1:0];
        ny           <= cnt_y[CNT_W-1:0];
        xfwd         <= !raw_x[7];
        yfwd         <= !raw_y[7];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (x_active) begin
          x_phase <= x_step;
          nx      <= nx - CNT_W'(1);
        end else if (ny != '0) begin
          y_phase <= y_step;
          ny      <= ny - CNT_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.x_drive     <= x_active ? x_step : x_phase;
      out_data.y_drive     <= (!x_active && (ny != '0)) ? y_step : y_phase;
      out_data.left_drive  <= button_drive[0];
      out_data.right_drive <= button_drive[1];
      out_data.last_step   <= sts.last;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qme_pkg::*;

  typedef enum logic {ROW_REPORT, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] limit;
    qme_in_t            rpt;
    logic               typed;
    qme_out_t           want;
  } dir_row_t;

  localparam int N_DIR = 27;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int N_RAND [3] = '{36, 36, 36};

  // Typed expectations only where they follow from reset state and the typed rows before.
  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h00, 1'b1, 1'b1}, 1'b1, '{2'd0, 2'd0, 1'b1, 1'b1, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'h01, 8'h00, 1'b1, 1'b0}, 1'b1, '{2'd1, 2'd0, 1'b1, 1'b0, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'hFF, 8'h00, 1'b0, 1'b1}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h01, 1'b0, 1'b0}, 1'b1, '{2'd0, 2'd1, 1'b0, 1'b0, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'hFF, 1'b0, 1'b0}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_REPORT, 6'd0,  '{8'h7F, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h80, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h7F, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h80, 1'b0, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h7F, 8'h80, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h80, 8'h7F, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h03, 8'hFB, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'hE0, 8'h21, 1'b0, 1'b1}, 1'b0, '0},
    '{ROW_LIMIT,  6'd0,  '0,                          1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h7F, 8'h80, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_LIMIT,  6'd63, '0,                          1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h80, 8'h80, 1'b0, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h28, 8'hD8, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_LIMIT,  6'd1,  '0,                          1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'hF9, 8'h09, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h00, 8'h80, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_LIMIT,  6'd33, '0,                          1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h64, 8'h9C, 1'b0, 1'b1}, 1'b0, '0},
    '{ROW_LIMIT,  6'd32, '0,                          1'b0, '0},
    '{ROW_REPORT, 6'd0,  '{8'h01, 8'h01, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  qme_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  qme_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // predicted block state
  logic [LIMIT_W-1:0] limit_m = LIMIT_RESET;
  logic [1:0]         x_m = '0;
  logic [1:0]         y_m = '0;
  logic [1:0]         btn_m = '0;

  qme_out_t    step_q [$];
  int unsigned n_err = 0;
  int unsigned n_reports = 0;
  int unsigned n_steps = 0;
  int unsigned n_limits = 0;
  int unsigned src_idle = 17;
  int unsigned snk_idle = 50;
  int unsigned quiet_cycles = 0;

  quadrature_mouse_emulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [1:0] gray_step(input logic [1:0] g, input bit fwd);
    logic [1:0] b;
    b = {g[1], g[1] ^ g[0]};
    b = fwd ? b + 2'd1 : b - 2'd1;
    return {b[1], b[1] ^ b[0]};
  endfunction

  function automatic int unsigned axis_count(input logic signed [7:0] d, input int unsigned lim);
    int mag;
    mag = int'(d);
    if (mag < 0) mag = -mag;
    return (mag > lim) ? lim : mag;
  endfunction

  function automatic void add_step(input bit keep, input bit last);
    qme_out_t r;
    r.x_drive     = x_m;
    r.y_drive     = y_m;
    r.left_drive  = btn_m[0];
    r.right_drive = btn_m[1];
    r.last_step   = last;
    if (keep) step_q.push_back(r);
  endfunction

  // Phase steps for one report; keep = 0 only advances the state.
  function automatic void predict_report(input qme_in_t rpt, input bit keep);
    int unsigned lim, nx, ny, total;
    lim   = (32'(limit_m) > MAX_AXIS_STEPS_DEF) ? MAX_AXIS_STEPS_DEF : 32'(limit_m);
    btn_m = {rpt.right_button, rpt.left_button};
    nx    = axis_count(rpt.dx, lim);
    ny    = axis_count(rpt.dy, lim);
    total = nx + ny;
    if (total == 0) add_step(keep, 1'b1);
    for (int k = 0; k < total; k++) begin
      if (k < nx) x_m = gray_step(x_m, !rpt.dx[7]);
      else y_m = gray_step(y_m, !rpt.dy[7]);
      add_step(keep, k + 1 == total);
    end
  endfunction

  function automatic logic [7:0] pick_move();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'($urandom_range(0, 8) - 4);
      2: return 8'($urandom);
      default: return $urandom_range(0, 1) ? 8'h7F : 8'h80;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  task automatic send_report(input qme_in_t rpt, input bit typed, input qme_out_t want);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rpt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_report(rpt, !typed);
    if (typed) step_q.push_back(want);
    n_reports++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (step_q.size() != 0);
  endtask

  task automatic write_step_limit(input logic [LIMIT_W-1:0] val);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_m = val;
    n_limits++;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= $urandom_range(0, 99) < snk_idle;
  end

  always @(posedge clk) begin : result_check
    qme_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (step_q.size() == 0) begin
        $error("unexpected transfer: %p", out_data);
        n_err++;
      end else begin
        want = step_q.pop_front();
        check_field("x_drive", 32'(want.x_drive), 32'(out_data.x_drive));
        check_field("y_drive", 32'(want.y_drive), 32'(out_data.y_drive));
        check_field("left_drive", 32'(want.left_drive), 32'(out_data.left_drive));
        check_field("right_drive", 32'(want.right_drive), 32'(out_data.right_drive));
        check_field("last_step", 32'(want.last_step), 32'(out_data.last_step));
        n_steps++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    qme_in_t rpt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].kind == ROW_LIMIT) write_step_limit(dir_tab[i].limit);
      else send_report(dir_tab[i].rpt, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle = 17;
          snk_idle = 50;
          write_step_limit(LIMIT_W'($urandom_range(1, 31)));
        end
        1: begin
          src_idle = 50;
          snk_idle = 17;
          write_step_limit(LIMIT_W'($urandom_range(33, 63)));
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
          write_step_limit(LIMIT_W'($urandom_range(0, 32)));
        end
      endcase
      for (int i = 0; i < N_RAND[ph]; i++) begin
        if (i == N_RAND[ph] / 2) hold_until_drained();
        rpt.dx           = pick_move();
        rpt.dy           = pick_move();
        rpt.left_button  = 1'($urandom_range(0, 1));
        rpt.right_button = 1'($urandom_range(0, 1));
        send_report(rpt, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d reports, %0d phase steps, %0d step-limit writes", n_reports, n_steps,
             n_limits);
    $display("limits 0, 1, 32 and above range; stalls on either side and none");
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
